// ===== rtl/bgp_path_attribute_parser_assert.svh =====
// Assertion helpers for the attribute parser
`ifndef BGP_PATH_ATTRIBUTE_PARSER_ASSERT_SVH
`define BGP_PATH_ATTRIBUTE_PARSER_ASSERT_SVH

// Clocked assertion, held off while reset is asserted
`define BPAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Plain implication
`define BPAP_ASSERT_IMPL(label, ante, cons, msg) \
    `BPAP_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/bpap_pkg.sv =====
package bpap_pkg;

    localparam logic [3:0] IK_ORIGIN    = 4'd0;
    localparam logic [3:0] IK_SEGSTART  = 4'd1;
    localparam logic [3:0] IK_ASN       = 4'd2;
    localparam logic [3:0] IK_NEXTHOP   = 4'd3;
    localparam logic [3:0] IK_MED       = 4'd4;
    localparam logic [3:0] IK_LOCALPREF = 4'd5;
    localparam logic [3:0] IK_AGGASN    = 4'd6;
    localparam logic [3:0] IK_AGGID     = 4'd7;
    localparam logic [3:0] IK_COMMUNITY = 4'd8;
    localparam logic [3:0] IK_MPNH      = 4'd9;
    localparam logic [3:0] IK_PFXLEN    = 4'd10;
    localparam logic [3:0] IK_PFXBYTE   = 4'd11;
    localparam logic [3:0] IK_RAW       = 4'd12;
    localparam logic [3:0] IK_STATUS    = 4'd13;

    localparam logic [3:0] AK_ORIGIN    = 4'd0;
    localparam logic [3:0] AK_ASPATH    = 4'd1;
    localparam logic [3:0] AK_NEXTHOP   = 4'd2;
    localparam logic [3:0] AK_MED       = 4'd3;
    localparam logic [3:0] AK_LOCALPREF = 4'd4;
    localparam logic [3:0] AK_ATOMIC    = 4'd5;
    localparam logic [3:0] AK_AGG       = 4'd6;
    localparam logic [3:0] AK_COMMUNITY = 4'd7;
    localparam logic [3:0] AK_AS4PATH   = 4'd8;
    localparam logic [3:0] AK_AS4AGG    = 4'd9;
    localparam logic [3:0] AK_MPREACH   = 4'd10;
    localparam logic [3:0] AK_MPUNREACH = 4'd11;
    localparam logic [3:0] AK_UNKNOWN   = 4'd12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADLEN  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam int FLAG_EXT_BIT = 4;

    typedef struct packed {
        logic [3:0]  item_kind;
        logic [31:0] field_value;
        logic [1:0]  field_aux;
        logic [1:0]  parse_status;
        logic [7:0]  attr_flags;
        logic [7:0]  attr_code;
        logic [3:0]  attr_kind;
        logic [16:0] consumed_length;
        logic        last;
    } t_item;

    // up to four results per input byte
    typedef struct packed {
        t_item [3:0] items;
        logic [2:0]  count;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [3:0] kind_of_code(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            8'd1:    k = AK_ORIGIN;
            8'd2:    k = AK_ASPATH;
            8'd3:    k = AK_NEXTHOP;
            8'd4:    k = AK_MED;
            8'd5:    k = AK_LOCALPREF;
            8'd6:    k = AK_ATOMIC;
            8'd7:    k = AK_AGG;
            8'd8:    k = AK_COMMUNITY;
            8'd17:   k = AK_AS4PATH;
            8'd18:   k = AK_AS4AGG;
            8'd14:   k = AK_MPREACH;
            8'd15:   k = AK_MPUNREACH;
            default: k = AK_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic t_item mk_item(input logic [3:0] kind, input logic [31:0] val,
                                      input logic [1:0] aux, input logic [7:0] flags,
                                      input logic [7:0] code, input logic [3:0] akind);
        t_item it;
        it.item_kind       = kind;
        it.field_value     = val;
        it.field_aux       = aux;
        it.parse_status    = ST_OK;
        it.attr_flags      = flags;
        it.attr_code       = code;
        it.attr_kind       = akind;
        it.consumed_length = '0;
        it.last            = 1'b0;
        return it;
    endfunction

    function automatic t_item mk_status(input logic [1:0] st, input logic [2:0] hdr,
                                        input logic [15:0] vpos, input logic [7:0] flags,
                                        input logic seen, input logic [7:0] code,
                                        input logic [3:0] akind);
        t_item it;
        it.item_kind       = IK_STATUS;
        it.field_value     = '0;
        it.field_aux       = '0;
        it.parse_status    = st;
        it.attr_flags      = flags;
        it.attr_code       = seen ? code : 8'd0;
        it.attr_kind       = seen ? akind : AK_UNKNOWN;
        it.consumed_length = {14'd0, hdr} + {1'b0, vpos};
        it.last            = 1'b1;
        return it;
    endfunction

endpackage

// ===== rtl/bpap_ifs.sv =====
interface bpap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface bpap_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_kind;
    logic [31:0] field_value;
    logic [1:0]  field_aux;
    logic [1:0]  parse_status;
    logic [7:0]  attr_flags;
    logic [7:0]  attr_code;
    logic [3:0]  attr_kind;
    logic [16:0] consumed_length;
    logic        last;

    modport source (output valid, output item_kind, output field_value, output field_aux,
                    output parse_status, output attr_flags, output attr_code,
                    output attr_kind, output consumed_length, output last, input ready);
    modport sink   (input valid, input item_kind, input field_value, input field_aux,
                    input parse_status, input attr_flags, input attr_code,
                    input attr_kind, input consumed_length, input last, output ready);
endinterface

// ===== rtl/bpap_front.sv =====
module bpap_front
    import bpap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_full,
    input  logic [7:0] i_byte,
    input  logic    i_eob,
    output logic    o_ready,
    output logic    o_push,
    output t_bundle o_bundle
);

    typedef enum logic [3:0] {
        PH_FLAGS, PH_CODE, PH_LENHI, PH_LENLO, PH_SKIP, PH_FIXED, PH_SEGTYPE,
        PH_SEGCOUNT, PH_SEGASN, PH_FAMILY, PH_NHLEN, PH_NH, PH_RESERVED,
        PH_PFXLEN, PH_PFXBYTES, PH_RAW
    } t_phase;

    function automatic logic [2:0] hdr_len(input t_phase ph, input logic ext);
        logic [2:0] h;
        priority if (ph == PH_CODE)  h = 3'd1;
        else if (ph == PH_LENHI)     h = 3'd2;
        else if (ph == PH_LENLO)     h = ext ? 3'd3 : 3'd2;
        else if (ph == PH_FLAGS)     h = 3'd0;
        else                         h = ext ? 3'd4 : 3'd3;
        return h;
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_flags, n_flags, r_code, n_code;
    logic [3:0]  r_kind, n_kind;
    logic [15:0] r_vlen, n_vlen, r_vpos, n_vpos;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_fbc, n_fbc;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_fam [3];
    logic [7:0]  n_fam [3];
    logic [1:0]  r_ferr, n_ferr;
    logic        r_seen, n_seen;

    logic        acc_in, st_fire;
    logic [1:0]  st_code, fam_idx;
    logic [2:0]  cnt, asz;
    logic [16:0] rem, rem1;
    logic [8:0]  nb;
    logic [15:0] asn_end;
    logic [3:0]  fk;
    t_item [3:0] items;

    assign o_ready = !i_full;
    assign acc_in  = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase; n_flags = r_flags; n_code = r_code; n_kind = r_kind;
        n_vlen = r_vlen; n_vpos = r_vpos; n_acc = r_acc; n_fbc = r_fbc;
        n_left = r_left; n_fam = r_fam; n_ferr = r_ferr; n_seen = r_seen;
        st_fire = 1'b0; st_code = ST_OK; cnt = 3'd0; items = '0;
        rem  = {1'b0, r_vlen} - {1'b0, r_vpos};
        rem1 = rem - 17'd1;
        asz  = (r_kind == AK_AS4PATH) ? 3'd4 : 3'd2;
        nb   = ({1'b0, i_byte} + 9'd7) >> 3;
        asn_end = (r_kind == AK_AGG) ? 16'd1 : 16'd3;
        fam_idx = (r_vpos[1:0] == 2'd0) ? 2'd0 : ((r_vpos < 16'd3) ? r_vpos[1:0] : 2'd2);
        fk = IK_COMMUNITY;
        if (acc_in) begin
            unique case (r_phase)
                PH_FLAGS: begin
                    n_flags = i_byte; n_code = '0; n_kind = '0; n_seen = 1'b0;
                    n_vlen = '0; n_vpos = '0; n_phase = PH_CODE;
                    if (i_eob) begin st_fire = 1'b1; st_code = ST_BADLEN; end
                end
                PH_CODE: begin
                    n_code = i_byte; n_kind = kind_of_code(i_byte); n_seen = 1'b1;
                    n_phase = r_flags[FLAG_EXT_BIT] ? PH_LENHI : PH_LENLO;
                    if (i_eob) begin st_fire = 1'b1; st_code = ST_BADLEN; end
                end
                PH_LENHI: begin
                    n_vlen = {i_byte, 8'd0}; n_phase = PH_LENLO;
                    if (i_eob) begin st_fire = 1'b1; st_code = ST_BADLEN; end
                end
                PH_LENLO: begin
                    n_vlen = r_flags[FLAG_EXT_BIT] ? {r_vlen[15:8], i_byte} : {8'd0, i_byte};
                    n_vpos = '0; n_ferr = ST_OK; n_acc = '0; n_fbc = '0; n_left = '0;
                    unique case (r_kind)
                        AK_ORIGIN: begin
                            n_phase = PH_FIXED;
                            if (n_vlen != 16'd1) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_NEXTHOP, AK_MED, AK_LOCALPREF: begin
                            n_phase = PH_FIXED;
                            if (n_vlen != 16'd4) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_ATOMIC: begin
                            n_phase = PH_FIXED;
                            if (n_vlen != 16'd0) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_AGG: begin
                            n_phase = PH_FIXED;
                            if (n_vlen != 16'd6) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_AS4AGG: begin
                            n_phase = PH_FIXED;
                            if (n_vlen != 16'd8) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_COMMUNITY: begin
                            n_phase = PH_FIXED;
                            if (n_vlen[1:0] != 2'd0) begin
                                n_ferr = ST_BADLEN; n_phase = PH_SKIP;
                            end
                        end
                        AK_ASPATH, AK_AS4PATH: n_phase = PH_SEGTYPE;
                        AK_MPREACH: begin
                            n_phase = PH_FAMILY;
                            if (n_vlen < 16'd5) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        AK_MPUNREACH: begin
                            n_phase = PH_FAMILY;
                            if (n_vlen < 16'd3) begin n_ferr = ST_BADLEN; n_phase = PH_SKIP; end
                        end
                        default: n_phase = PH_RAW;
                    endcase
                    if (n_vlen == 16'd0) begin st_fire = 1'b1; st_code = n_ferr; end
                    else if (i_eob) begin st_fire = 1'b1; st_code = ST_BADLEN; end
                end
                default: begin
                    unique case (r_phase)
                        PH_FIXED: begin
                            n_acc = {r_acc[23:0], i_byte};
                            n_fbc = r_fbc + 3'd1;
                            if (r_kind == AK_ORIGIN) begin
                                if (i_byte > 8'd2) begin
                                    n_ferr = (r_ferr == ST_OK) ? ST_INVALID : r_ferr;
                                    n_phase = PH_SKIP;
                                end else begin
                                    items[0] = mk_item(IK_ORIGIN, {24'd0, i_byte}, 2'd0,
                                                       r_flags, r_code, r_kind);
                                    cnt = 3'd1;
                                end
                            end else if (r_kind == AK_AGG || r_kind == AK_AS4AGG) begin
                                if (r_vpos == asn_end) begin
                                    items[0] = mk_item(IK_AGGASN, n_acc,
                                                       {1'b0, r_kind == AK_AS4AGG},
                                                       r_flags, r_code, r_kind);
                                    cnt = 3'd1; n_acc = '0; n_fbc = '0;
                                end else if (r_vpos == asn_end + 16'd4) begin
                                    items[0] = mk_item(IK_AGGID, n_acc, 2'd0,
                                                       r_flags, r_code, r_kind);
                                    cnt = 3'd1;
                                end
                            end else if (n_fbc == 3'd4) begin
                                priority if (r_kind == AK_NEXTHOP) fk = IK_NEXTHOP;
                                else if (r_kind == AK_MED)          fk = IK_MED;
                                else if (r_kind == AK_LOCALPREF)    fk = IK_LOCALPREF;
                                else                                fk = IK_COMMUNITY;
                                items[0] = mk_item(fk, n_acc, 2'd0, r_flags, r_code, r_kind);
                                cnt = 3'd1; n_acc = '0; n_fbc = '0;
                            end
                        end
                        PH_SEGTYPE: begin
                            if (rem < 17'd2) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_BADLEN : r_ferr;
                                n_phase = PH_SKIP;
                            end else if (i_byte < 8'd1 || i_byte > 8'd2) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_INVALID : r_ferr;
                                n_phase = PH_SKIP;
                            end else begin
                                n_acc = {24'd0, i_byte}; n_phase = PH_SEGCOUNT;
                            end
                        end
                        PH_SEGCOUNT: begin
                            if (rem1 < ((asz == 3'd4) ? {7'd0, i_byte, 2'd0}
                                                      : {8'd0, i_byte, 1'b0})) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_BADLEN : r_ferr;
                                n_phase = PH_SKIP;
                            end else begin
                                items[0] = mk_item(IK_SEGSTART, {24'd0, i_byte}, r_acc[1:0],
                                                   r_flags, r_code, r_kind);
                                cnt = 3'd1; n_acc = '0; n_fbc = '0; n_left = i_byte;
                                n_phase = (i_byte == 8'd0) ? PH_SEGTYPE : PH_SEGASN;
                            end
                        end
                        PH_SEGASN: begin
                            n_acc = {r_acc[23:0], i_byte};
                            n_fbc = r_fbc + 3'd1;
                            if (n_fbc >= asz) begin
                                items[0] = mk_item(IK_ASN, n_acc, 2'd0, r_flags, r_code, r_kind);
                                cnt = 3'd1; n_acc = '0; n_fbc = '0;
                                n_left = r_left - 8'd1;
                                if (n_left == 8'd0) n_phase = PH_SEGTYPE;
                            end
                        end
                        PH_FAMILY: begin
                            n_fam[fam_idx] = i_byte;
                            if (r_vpos >= 16'd2) begin
                                if (n_fam[0] == 8'd0 && n_fam[1] == 8'd2 && n_fam[2] == 8'd1) begin
                                    n_phase = (r_kind == AK_MPREACH) ? PH_NHLEN : PH_PFXLEN;
                                end else begin
                                    // not IPv6 unicast: pass the value through as raw bytes
                                    n_kind = AK_UNKNOWN;
                                    items[0] = mk_item(IK_RAW, {24'd0, n_fam[0]}, 2'd0,
                                                       r_flags, r_code, AK_UNKNOWN);
                                    items[1] = mk_item(IK_RAW, {24'd0, n_fam[1]}, 2'd0,
                                                       r_flags, r_code, AK_UNKNOWN);
                                    items[2] = mk_item(IK_RAW, {24'd0, n_fam[2]}, 2'd0,
                                                       r_flags, r_code, AK_UNKNOWN);
                                    cnt = 3'd3; n_phase = PH_RAW;
                                end
                            end
                        end
                        PH_NHLEN: begin
                            if (i_byte != 8'd16 && i_byte != 8'd32) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_INVALID : r_ferr;
                                n_phase = PH_SKIP;
                            end else if (rem1 < {9'd0, i_byte} + 17'd1) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_BADLEN : r_ferr;
                                n_phase = PH_SKIP;
                            end else begin
                                n_left = i_byte; n_phase = PH_NH;
                            end
                        end
                        PH_NH: begin
                            items[0] = mk_item(IK_MPNH, {24'd0, i_byte}, 2'd0,
                                               r_flags, r_code, r_kind);
                            cnt = 3'd1; n_left = r_left - 8'd1;
                            if (n_left == 8'd0) n_phase = PH_RESERVED;
                        end
                        PH_RESERVED: begin
                            if (i_byte != 8'd0) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_INVALID : r_ferr;
                                n_phase = PH_SKIP;
                            end else n_phase = PH_PFXLEN;
                        end
                        PH_PFXLEN: begin
                            if (i_byte > 8'd128) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_INVALID : r_ferr;
                                n_phase = PH_SKIP;
                            end else if (rem1 < {8'd0, nb}) begin
                                n_ferr = (r_ferr == ST_OK) ? ST_BADLEN : r_ferr;
                                n_phase = PH_SKIP;
                            end else begin
                                items[0] = mk_item(IK_PFXLEN, {24'd0, i_byte}, 2'd0,
                                                   r_flags, r_code, r_kind);
                                cnt = 3'd1; n_left = nb[7:0];
                                if (nb != 9'd0) n_phase = PH_PFXBYTES;
                            end
                        end
                        PH_PFXBYTES: begin
                            items[0] = mk_item(IK_PFXBYTE, {24'd0, i_byte}, 2'd0,
                                               r_flags, r_code, r_kind);
                            cnt = 3'd1; n_left = r_left - 8'd1;
                            if (n_left == 8'd0) n_phase = PH_PFXLEN;
                        end
                        PH_RAW: begin
                            items[0] = mk_item(IK_RAW, {24'd0, i_byte}, 2'd0,
                                               r_flags, r_code, r_kind);
                            cnt = 3'd1;
                        end
                        default: ;
                    endcase
                    n_vpos = r_vpos + 16'd1;
                    if (n_vpos >= r_vlen) begin st_fire = 1'b1; st_code = n_ferr; end
                    else if (i_eob) begin st_fire = 1'b1; st_code = ST_BADLEN; end
                end
            endcase
            if (st_fire) begin
                items[cnt[1:0]] = mk_status(st_code, hdr_len(n_phase, n_flags[FLAG_EXT_BIT]),
                                            n_vpos, n_flags, n_seen, n_code, n_kind);
                cnt = cnt + 3'd1;
                n_phase = PH_FLAGS;
            end
        end
    end

    assign o_push         = acc_in && (cnt != 3'd0);
    assign o_bundle.items = items;
    assign o_bundle.count = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS; r_flags <= '0; r_code <= '0; r_kind <= '0;
            r_vlen <= '0; r_vpos <= '0; r_acc <= '0; r_fbc <= '0; r_left <= '0;
            r_fam <= '{default: '0}; r_ferr <= ST_OK; r_seen <= 1'b0;
        end else begin
            r_phase <= n_phase; r_flags <= n_flags; r_code <= n_code; r_kind <= n_kind;
            r_vlen <= n_vlen; r_vpos <= n_vpos; r_acc <= n_acc; r_fbc <= n_fbc;
            r_left <= n_left; r_fam <= n_fam; r_ferr <= n_ferr; r_seen <= n_seen;
        end
    end

endmodule

// ===== rtl/bpap_queue.sv =====
module bpap_queue
    import bpap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_bundle,
    output t_q_stat o_stat
);

    t_bundle    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_bundle     = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== rtl/bpap_back.sv =====
module bpap_back
    import bpap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_bundle,
    input  t_q_stat i_stat,
    input  logic    i_ready,
    output logic    o_pop,
    output logic    o_valid,
    output t_item   o_item
);

    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       done;

    // current transaction leaves and it was the last one of the bundle
    assign done    = r_valid && i_ready && ({1'b0, r_idx} + 3'd1 == r_bundle.count);
    assign o_pop   = (!r_valid || done) && !i_stat.empty;
    assign o_valid = r_valid;
    assign o_item  = r_bundle.items[r_idx];

    always_ff @(posedge i_clk) begin
        if (o_pop) r_bundle <= i_bundle;
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_idx <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1; r_idx <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// ===== rtl/bgp_path_attribute_parser.sv =====
// Path: a byte's first result is registered in the queue and then in the serializer
// before it shows. Throughput: one byte per cycle while each byte yields at most one
// result and the output is ready; a byte with several results holds the output until
// all are sent, and the two-entry queue absorbs short bursts before input ready drops.
// Reset: i_rst_n synchronous, active low; parser waits for a flags byte, queue empty.
`include "bgp_path_attribute_parser_assert.svh"
module bgp_path_attribute_parser
    import bpap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bpap_in_if.sink    i_in,
    bpap_out_if.source o_out
);

    t_bundle f_bundle, q_bundle;
    t_q_stat q_stat;
    t_item   item;
    logic    push, pop;

    bpap_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (i_in.valid),
        .i_full  (q_stat.full),
        .i_byte  (i_in.data_byte),
        .i_eob   (i_in.end_of_buffer),
        .o_ready (i_in.ready),
        .o_push  (push),
        .o_bundle(f_bundle)
    );

    bpap_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_bundle(f_bundle),
        .i_pop   (pop),
        .o_bundle(q_bundle),
        .o_stat  (q_stat)
    );

    bpap_back u_back (
        .i_clk, .i_rst_n,
        .i_bundle(q_bundle),
        .i_stat  (q_stat),
        .i_ready (o_out.ready),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .o_item  (item)
    );

    assign o_out.item_kind       = item.item_kind;
    assign o_out.field_value     = item.field_value;
    assign o_out.field_aux       = item.field_aux;
    assign o_out.parse_status    = item.parse_status;
    assign o_out.attr_flags      = item.attr_flags;
    assign o_out.attr_code       = item.attr_code;
    assign o_out.attr_kind       = item.attr_kind;
    assign o_out.consumed_length = item.consumed_length;
    assign o_out.last            = item.last;

    `BPAP_ASSERT(a_q_sane, !(q_stat.full && q_stat.empty), "queue full and empty")
    `BPAP_ASSERT_IMPL(a_last_status, o_out.valid && o_out.last,
        o_out.item_kind == IK_STATUS, "last set on a non-status transaction")
    `BPAP_ASSERT_IMPL(a_status_len, o_out.valid && o_out.item_kind == IK_STATUS,
        o_out.consumed_length != 17'd0 && o_out.last, "status without length")

endmodule
